// ----- rtl/ffha_pkg.sv -----
// Package for the first-fit heap allocator.
// Holds field widths, status codes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int OFF_W = 16;
  localparam int REQ_W = 16;
  localparam int GNT_W = 17;
  localparam int STS_W = 3;

  // Operation codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_NO_FIT    = 3'd1;
  localparam logic [STS_W-1:0] STS_REC_FULL  = 3'd2;
  localparam logic [STS_W-1:0] STS_BAD_PTR   = 3'd3;
  localparam logic [STS_W-1:0] STS_FREE_FULL = 3'd4;

  // Minimum granted payload and rounding mask.
  localparam int MIN_BYTES  = 256;
  localparam int ROUND_MASK = 7;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_A_RD,
    S_A_CK,
    S_A_US,
    S_A_UPD,
    S_R_RD,
    S_R_CK,
    S_P_RD,
    S_P_CK,
    S_PV_RD,
    S_PV_CK,
    S_DEC,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_OUT
  } state_e;

endpackage

// ----- rtl/ffha_in_if.sv -----
// Request channel interface of the heap allocator.
// Depends on ffha_pkg for field widths.
`timescale 1ns / 1ps

interface ffha_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ffha_pkg::REQ_W-1:0] request_bytes;
  logic [ffha_pkg::OFF_W-1:0] release_offset;

  modport source (output valid, operation, request_bytes, release_offset, input ready);
  modport sink   (input valid, operation, request_bytes, release_offset, output ready);
endinterface

// ----- rtl/ffha_out_if.sv -----
// Result channel interface of the heap allocator.
// Depends on ffha_pkg for field widths.
`timescale 1ns / 1ps

interface ffha_out_if;
  logic                       valid;
  logic                       ready;
  logic [ffha_pkg::OFF_W-1:0] payload_offset;
  logic [ffha_pkg::GNT_W-1:0] granted_bytes;
  logic [ffha_pkg::STS_W-1:0] status;

  modport source (output valid, payload_offset, granted_bytes, status, input ready);
  modport sink   (input valid, payload_offset, granted_bytes, status, output ready);
endinterface

// ----- rtl/first_fit_heap_allocator_top.sv -----
// Channel  | Dir | Payload                                        | Transfer
// in_i     | in  | operation, request_bytes, release_offset       | valid & ready
// out_o    | out | payload_offset, granted_bytes, status          | valid & ready
//
// One request at a time. Allocate walks the free extents in order, then scans
// the record slots, then shifts later extents down when an extent is removed.
// Release compares records, walks the extents in address order, and shifts
// later extents up on insertion or down when both neighbours merge.
// After reset the S_INIT state seeds the first free extent before in_i is ready.
// The result is held in out_o until transferred; in_i is not ready meanwhile.
//
// Top level of the first-fit heap allocator; depends on ffha_pkg and the
// channel interfaces ffha_in_if and ffha_out_if.
`timescale 1ns / 1ps

module first_fit_heap_allocator_top #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16,
  parameter int FREE_SLOTS   = 64,
  parameter int USED_SLOTS   = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_in_if.sink    in_i,
  ffha_out_if.source out_o
);
  import ffha_pkg::*;

  localparam int LW  = $clog2(HEAP_BYTES + 1);
  localparam int CW  = ((LW > GNT_W) ? LW : GNT_W) + 2;
  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UIW = $clog2(USED_SLOTS);

  localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);

  // Tables and their registered read data.
  logic [LW-1:0] fs_mem [FREE_SLOTS];
  logic [LW-1:0] fl_mem [FREE_SLOTS];
  logic [LW-1:0] us_mem [USED_SLOTS];
  logic [LW-1:0] ul_mem [USED_SLOTS];
  logic [LW-1:0] fs_rd_q, fl_rd_q, us_rd_q, ul_rd_q;

  // Sequencer registers.
  state_e            state_q, state_d;
  logic [FCW-1:0]    cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d;
  logic [UIW-1:0]    uidx_q, uidx_d, slot_q, slot_d;
  logic [CW-1:0]     size_q, size_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [LW-1:0]     st_q, st_d, ln_q, ln_d, nx_q, nx_d, pv_q, pv_d;
  logic              nt_q, nt_d, pt_q, pt_d;
  logic [OFF_W-1:0]  roff_q, roff_d;
  logic [GNT_W-1:0]  rlen_q, rlen_d;
  logic [STS_W-1:0]  rsts_q, rsts_d;
  logic [USED_SLOTS-1:0] uv_q;

  // Memory port controls.
  logic [FIW-1:0] f_ra, f_wa;
  logic           f_we_s, f_we_l;
  logic [LW-1:0]  f_ws, f_wl;
  logic [UIW-1:0] u_ra;
  logic           u_we, uv_set, uv_clr;
  logic [LW-1:0]  u_wl;
  logic [CW-1:0]  rnd;

  // Free extent table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (f_we_s) fs_mem[f_wa] <= f_ws;
    if (f_we_l) fl_mem[f_wa] <= f_wl;
    fs_rd_q <= fs_mem[f_ra];
    fl_rd_q <= fl_mem[f_ra];
  end

  // Allocation record table.
  always_ff @(posedge clk_i) begin
    if (u_we) begin
      us_mem[slot_q] <= st_q;
      ul_mem[slot_q] <= u_wl;
    end
    us_rd_q <= us_mem[u_ra];
    ul_rd_q <= ul_mem[u_ra];
  end

  // Control state and record valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= FCW'(1);
      uv_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (uv_set) uv_q[slot_q] <= 1'b1;
      if (uv_clr) uv_q[slot_q] <= 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    uidx_q <= uidx_d;
    slot_q <= slot_d;
    size_q <= size_d;
    off_q  <= off_d;
    st_q   <= st_d;
    ln_q   <= ln_d;
    nx_q   <= nx_d;
    pv_q   <= pv_d;
    nt_q   <= nt_d;
    pt_q   <= pt_d;
    roff_q <= roff_d;
    rlen_q <= rlen_d;
    rsts_q <= rsts_d;
  end

  // Request size rounded up to eight bytes.
  assign rnd = (CW'(in_i.request_bytes) + CW'(ROUND_MASK)) & ~CW'(ROUND_MASK);

  // Sequencer: next state and memory controls.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    uidx_d  = uidx_q;
    slot_d  = slot_q;
    size_d  = size_q;
    off_d   = off_q;
    st_d    = st_q;
    ln_d    = ln_q;
    nx_d    = nx_q;
    pv_d    = pv_q;
    nt_d    = nt_q;
    pt_d    = pt_q;
    roff_d  = roff_q;
    rlen_d  = rlen_q;
    rsts_d  = rsts_q;
    f_ra    = idx_q[FIW-1:0];
    f_wa    = idx_q[FIW-1:0];
    f_we_s  = 1'b0;
    f_we_l  = 1'b0;
    f_ws    = fs_rd_q;
    f_wl    = fl_rd_q;
    u_ra    = uidx_q;
    u_we    = 1'b0;
    u_wl    = ln_q;
    uv_set  = 1'b0;
    uv_clr  = 1'b0;

    unique case (state_q)
      // Seed the whole heap as one free extent.
      S_INIT: begin
        f_wa    = '0;
        f_we_s  = 1'b1;
        f_we_l  = 1'b1;
        f_ws    = '0;
        f_wl    = LW'(HEAP_BYTES - HEADER_BYTES);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          idx_d  = '0;
          uidx_d = '0;
          off_d  = in_i.release_offset;
          size_d = (rnd < CW'(MIN_BYTES)) ? CW'(MIN_BYTES) : rnd;
          roff_d = '0;
          rlen_d = '0;
          rsts_d = STS_OK;
          if (in_i.operation == OP_ALLOC) begin
            state_d = S_A_RD;
          end else if (in_i.release_offset == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_R_RD;
          end
        end
      end
      // First-fit walk of the free table.
      S_A_RD: begin
        if (idx_q == cnt_q) begin
          rsts_d  = STS_NO_FIT;
          state_d = S_OUT;
        end else begin
          state_d = S_A_CK;
        end
      end
      S_A_CK: begin
        if (CW'(fl_rd_q) >= size_q) begin
          pos_d   = idx_q;
          st_d    = fs_rd_q;
          ln_d    = fl_rd_q;
          state_d = S_A_US;
        end else begin
          idx_d   = FCW'(idx_q + 1'b1);
          state_d = S_A_RD;
        end
      end
      // Look for a free record slot.
      S_A_US: begin
        if (!uv_q[uidx_q]) begin
          slot_d  = uidx_q;
          state_d = S_A_UPD;
        end else if (uidx_q == UIW'(USED_SLOTS - 1)) begin
          rsts_d  = STS_REC_FULL;
          state_d = S_OUT;
        end else begin
          uidx_d = UIW'(uidx_q + 1'b1);
        end
      end
      // Record the block, then split or remove the extent.
      S_A_UPD: begin
        roff_d = OFF_W'(CW'(st_q) + HDR_C);
        rsts_d = STS_OK;
        uv_set = 1'b1;
        u_we   = 1'b1;
        f_wa   = pos_q[FIW-1:0];
        if (CW'(ln_q) < size_q + HDR_C) begin
          rlen_d  = GNT_W'(ln_q);
          idx_d   = pos_q;
          state_d = S_DN_RD;
        end else begin
          rlen_d  = GNT_W'(size_q);
          u_wl    = LW'(size_q);
          f_we_s  = 1'b1;
          f_we_l  = 1'b1;
          f_ws    = LW'(CW'(st_q) + HDR_C + size_q);
          f_wl    = LW'(CW'(ln_q) - HDR_C - size_q);
          state_d = S_OUT;
        end
      end
      // Look up the record of the released block.
      S_R_RD: state_d = S_R_CK;
      S_R_CK: begin
        if (uv_q[uidx_q] && (CW'(us_rd_q) + HDR_C == CW'(off_q))) begin
          st_d    = us_rd_q;
          ln_d    = ul_rd_q;
          slot_d  = uidx_q;
          idx_d   = '0;
          state_d = S_P_RD;
        end else if (uidx_q == UIW'(USED_SLOTS - 1)) begin
          rsts_d  = STS_BAD_PTR;
          state_d = S_OUT;
        end else begin
          uidx_d  = UIW'(uidx_q + 1'b1);
          state_d = S_R_RD;
        end
      end
      // Find the insertion point in address order.
      S_P_RD: begin
        if (idx_q == cnt_q) begin
          pos_d   = idx_q;
          nt_d    = 1'b0;
          state_d = S_PV_RD;
        end else begin
          state_d = S_P_CK;
        end
      end
      S_P_CK: begin
        if (fs_rd_q >= st_q) begin
          pos_d   = idx_q;
          nx_d    = fl_rd_q;
          nt_d    = (CW'(st_q) + HDR_C + CW'(ln_q) == CW'(fs_rd_q));
          state_d = S_PV_RD;
        end else begin
          idx_d   = FCW'(idx_q + 1'b1);
          state_d = S_P_RD;
        end
      end
      // Fetch the preceding extent.
      S_PV_RD: begin
        f_ra = FIW'(pos_q - 1'b1);
        if (pos_q == '0) begin
          pt_d    = 1'b0;
          state_d = S_DEC;
        end else begin
          state_d = S_PV_CK;
        end
      end
      S_PV_CK: begin
        pv_d    = fl_rd_q;
        pt_d    = (CW'(fs_rd_q) + HDR_C + CW'(fl_rd_q) == CW'(st_q));
        state_d = S_DEC;
      end
      // Merge, insert or refuse.
      S_DEC: begin
        if (!nt_q && !pt_q && (cnt_q >= FCW'(FREE_SLOTS))) begin
          rsts_d  = STS_FREE_FULL;
          state_d = S_OUT;
        end else begin
          uv_clr = 1'b1;
          if (nt_q && pt_q) begin
            f_wa    = FIW'(pos_q - 1'b1);
            f_we_l  = 1'b1;
            f_wl    = LW'(CW'(pv_q) + HDR_C + CW'(ln_q) + HDR_C + CW'(nx_q));
            idx_d   = pos_q;
            state_d = S_DN_RD;
          end else if (nt_q) begin
            f_wa    = pos_q[FIW-1:0];
            f_we_s  = 1'b1;
            f_we_l  = 1'b1;
            f_ws    = st_q;
            f_wl    = LW'(CW'(ln_q) + HDR_C + CW'(nx_q));
            state_d = S_OUT;
          end else if (pt_q) begin
            f_wa    = FIW'(pos_q - 1'b1);
            f_we_l  = 1'b1;
            f_wl    = LW'(CW'(pv_q) + HDR_C + CW'(ln_q));
            state_d = S_OUT;
          end else begin
            idx_d   = cnt_q;
            state_d = S_UP_RD;
          end
        end
      end
      // Remove an extent by moving the later ones down.
      S_DN_RD: begin
        f_ra = FIW'(idx_q + 1'b1);
        if (FCW'(idx_q + 1'b1) < cnt_q) begin
          state_d = S_DN_WR;
        end else begin
          cnt_d   = FCW'(cnt_q - 1'b1);
          state_d = S_OUT;
        end
      end
      S_DN_WR: begin
        f_we_s  = 1'b1;
        f_we_l  = 1'b1;
        idx_d   = FCW'(idx_q + 1'b1);
        state_d = S_DN_RD;
      end
      // Open a gap by moving the later extents up, then insert.
      S_UP_RD: begin
        f_ra = FIW'(idx_q - 1'b1);
        if (idx_q > pos_q) begin
          state_d = S_UP_WR;
        end else begin
          f_wa    = pos_q[FIW-1:0];
          f_we_s  = 1'b1;
          f_we_l  = 1'b1;
          f_ws    = st_q;
          f_wl    = ln_q;
          cnt_d   = FCW'(cnt_q + 1'b1);
          state_d = S_OUT;
        end
      end
      S_UP_WR: begin
        f_we_s  = 1'b1;
        f_we_l  = 1'b1;
        idx_d   = FCW'(idx_q - 1'b1);
        state_d = S_UP_RD;
      end
      // Hold the result until it is transferred.
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = (state_q == S_OUT);
  assign out_o.payload_offset = roff_q;
  assign out_o.granted_bytes  = rlen_q;
  assign out_o.status         = rsts_q;

endmodule
